FILE: rtl/gfog_pkg.sv
// ----------------------------------------------------------------------------
// gfog_pkg
// Shared types and constants of the GNSS fix outlier gate.
// ----------------------------------------------------------------------------
package gfog_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam int unsigned MidQueueDepth = 2;
  localparam int unsigned OutQueueDepth = 2;

  typedef enum logic [CfgIdxW-1:0] {
    RegGateEnabled   = 3'd0,
    RegMaxAccuracy   = 3'd1,
    RegMinSpeed      = 3'd2,
    RegStaleTimeout  = 3'd3,
    RegJumpLimit     = 3'd4,
    RegValidNeeded   = 3'd5,
    RegOutlierLimit  = 3'd6
  } reg_idx_e;

  typedef enum logic [3:0] {
    DecDisabled    = 4'd0,
    DecNotRtk      = 4'd1,
    DecInaccurate  = 4'd2,
    DecStale       = 4'd3,
    DecCollecting  = 4'd4,
    DecInitFix     = 4'd5,
    DecPosUpd      = 4'd6,
    DecPosHeading  = 4'd7,
    DecOutlier     = 4'd8,
    DecForcedReset = 4'd9
  } dec_e;

  // reset values (squares of speed and jump limit held directly)
  localparam logic        GateEnabledRst   = 1'b1;
  localparam logic [15:0] MaxAccuracyRst   = 16'd100;
  localparam logic [31:0] SpeedSqRst       = 32'd100;
  localparam logic [15:0] StaleTimeoutRst  = 16'd5000;
  localparam logic [31:0] JumpSqRst        = 32'd25000000;
  localparam logic [7:0]  ValidNeededRst   = 8'd10;
  localparam logic [3:0]  OutlierLimitRst  = 4'd10;

  localparam logic [7:0]  InlierMax  = 8'd255;
  localparam logic [3:0]  OutlierMax = 4'd15;
  localparam logic [15:0] DiffSat    = 16'hFFFF;

  typedef struct packed {
    logic        gate_enabled;
    logic [15:0] max_accuracy;
    logic [31:0] speed_sq;
    logic [15:0] stale_timeout;
    logic [31:0] jump_sq;
    logic [7:0]  valid_needed;
    logic [3:0]  outlier_limit;
  } cfg_t;

  // classified request between front and back
  typedef struct packed {
    logic               dropped;
    dec_e               drop_dec;
    logic               fast;
    logic [31:0]        arrival;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [15:0] mx;
    logic signed [15:0] my;
  } item_t;

  typedef struct packed {
    dec_e               dec;
    logic               trusted;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [15:0] mx;
    logic signed [15:0] my;
  } result_t;

endpackage

FILE: rtl/gfog_fifo.sv
// ----------------------------------------------------------------------------
// gfog_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module gfog_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: rtl/gfog_cfg.sv
// ----------------------------------------------------------------------------
// gfog_cfg
// Configuration registers; speed and jump limits are held as squares.
// ----------------------------------------------------------------------------
module gfog_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [gfog_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [gfog_pkg::CfgDataW-1:0] cfg_wdata_i,
  output gfog_pkg::cfg_t               cfg_o
);

  gfog_pkg::cfg_t cfg_q, cfg_d;
  logic [31:0]    wdata_sq;

  assign wdata_sq = {16'b0, cfg_wdata_i} * {16'b0, cfg_wdata_i};
  assign cfg_o    = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        gfog_pkg::RegGateEnabled:  cfg_d.gate_enabled  = cfg_wdata_i[0];
        gfog_pkg::RegMaxAccuracy:  cfg_d.max_accuracy  = cfg_wdata_i;
        gfog_pkg::RegMinSpeed:     cfg_d.speed_sq      = wdata_sq;
        gfog_pkg::RegStaleTimeout: cfg_d.stale_timeout = cfg_wdata_i;
        gfog_pkg::RegJumpLimit:    cfg_d.jump_sq       = wdata_sq;
        gfog_pkg::RegValidNeeded:  cfg_d.valid_needed  = cfg_wdata_i[7:0];
        gfog_pkg::RegOutlierLimit: cfg_d.outlier_limit = cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gate_enabled  <= gfog_pkg::GateEnabledRst;
      cfg_q.max_accuracy  <= gfog_pkg::MaxAccuracyRst;
      cfg_q.speed_sq      <= gfog_pkg::SpeedSqRst;
      cfg_q.stale_timeout <= gfog_pkg::StaleTimeoutRst;
      cfg_q.jump_sq       <= gfog_pkg::JumpSqRst;
      cfg_q.valid_needed  <= gfog_pkg::ValidNeededRst;
      cfg_q.outlier_limit <= gfog_pkg::OutlierLimitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

FILE: rtl/gfog_front.sv
// ----------------------------------------------------------------------------
// gfog_front
// Stateless classification: drop reasons and motion speed test.
// ----------------------------------------------------------------------------
module gfog_front (
  input  gfog_pkg::cfg_t     cfg_i,
  input  logic [31:0]        arrival_ms_i,
  input  logic               rtk_fixed_i,
  input  logic [15:0]        accuracy_mm_i,
  input  logic signed [31:0] fix_x_mm_i,
  input  logic signed [31:0] fix_y_mm_i,
  input  logic signed [15:0] motion_x_mm_s_i,
  input  logic signed [15:0] motion_y_mm_s_i,
  output gfog_pkg::item_t    item_o
);

  logic signed [31:0] mx_w, my_w;
  logic [31:0]        mx_sq, my_sq, speed_sq;

  assign mx_w     = 32'(motion_x_mm_s_i);
  assign my_w     = 32'(motion_y_mm_s_i);
  assign mx_sq    = mx_w * mx_w;
  assign my_sq    = my_w * my_w;
  assign speed_sq = mx_sq + my_sq;

  always_comb begin
    item_o          = '0;
    item_o.dropped  = 1'b1;
    item_o.drop_dec = gfog_pkg::DecDisabled;
    if (!cfg_i.gate_enabled) begin
      item_o.drop_dec = gfog_pkg::DecDisabled;
    end else if (!rtk_fixed_i) begin
      item_o.drop_dec = gfog_pkg::DecNotRtk;
    end else if (accuracy_mm_i > cfg_i.max_accuracy) begin
      item_o.drop_dec = gfog_pkg::DecInaccurate;
    end else begin
      item_o.dropped = 1'b0;
    end
    item_o.fast    = (speed_sq >= cfg_i.speed_sq);
    item_o.arrival = arrival_ms_i;
    item_o.x       = fix_x_mm_i;
    item_o.y       = fix_y_mm_i;
    item_o.mx      = motion_x_mm_s_i;
    item_o.my      = motion_y_mm_s_i;
  end

endmodule

FILE: rtl/gfog_back.sv
// ----------------------------------------------------------------------------
// gfog_back
// Tracking state: staleness, distance gate, counters and decisions.
// ----------------------------------------------------------------------------
module gfog_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gfog_pkg::cfg_t      cfg_i,
  input  logic                item_valid_i,
  input  gfog_pkg::item_t     item_i,
  output logic                item_take_o,
  input  logic                res_full_i,
  output logic                res_push_o,
  output gfog_pkg::result_t   res_o
);

  logic               trusted_q, trusted_d;
  logic [7:0]         inl_q, inl_d, inl_inc;
  logic [3:0]         outl_q, outl_d, outl_inc;
  logic signed [31:0] kept_x_q, kept_x_d, kept_y_q, kept_y_d;
  logic [31:0]        kept_t_q, kept_t_d;

  logic [31:0]        elapsed;
  logic               stale;
  logic signed [32:0] dx, dy;
  logic [32:0]        dx_mag, dy_mag;
  logic [15:0]        dx_sat, dy_sat;
  logic [31:0]        dx_sq, dy_sq;
  logic [32:0]        dist_sq;
  logic               inlier;

  assign item_take_o = item_valid_i & ~res_full_i;
  assign res_push_o  = item_take_o;

  assign elapsed = item_i.arrival - kept_t_q;
  assign stale   = elapsed > {16'b0, cfg_i.stale_timeout};

  assign dx      = 33'(item_i.x) - 33'(kept_x_q);
  assign dy      = 33'(item_i.y) - 33'(kept_y_q);
  assign dx_mag  = dx[32] ? 33'(-dx) : 33'(dx);
  assign dy_mag  = dy[32] ? 33'(-dy) : 33'(dy);
  assign dx_sat  = (dx_mag > {17'b0, gfog_pkg::DiffSat}) ? gfog_pkg::DiffSat : dx_mag[15:0];
  assign dy_sat  = (dy_mag > {17'b0, gfog_pkg::DiffSat}) ? gfog_pkg::DiffSat : dy_mag[15:0];
  assign dx_sq   = {16'b0, dx_sat} * {16'b0, dx_sat};
  assign dy_sq   = {16'b0, dy_sat} * {16'b0, dy_sat};
  assign dist_sq = {1'b0, dx_sq} + {1'b0, dy_sq};
  assign inlier  = dist_sq < {1'b0, cfg_i.jump_sq};

  assign inl_inc  = (inl_q == gfog_pkg::InlierMax) ? inl_q : inl_q + 1'b1;
  assign outl_inc = (outl_q == gfog_pkg::OutlierMax) ? outl_q : outl_q + 1'b1;

  always_comb begin
    trusted_d = trusted_q;
    inl_d     = inl_q;
    outl_d    = outl_q;
    kept_x_d  = kept_x_q;
    kept_y_d  = kept_y_q;
    kept_t_d  = kept_t_q;
    res_o     = '0;
    res_o.dec = item_i.drop_dec;
    if (item_i.dropped) begin
      res_o.dec = item_i.drop_dec;
    end else if (stale) begin
      trusted_d = 1'b0;
      inl_d     = '0;
      outl_d    = '0;
      kept_x_d  = item_i.x;
      kept_y_d  = item_i.y;
      kept_t_d  = item_i.arrival;
      res_o.dec = gfog_pkg::DecStale;
    end else if (inlier) begin
      kept_x_d = item_i.x;
      kept_y_d = item_i.y;
      kept_t_d = item_i.arrival;
      outl_d   = '0;
      inl_d    = inl_inc;
      if (!trusted_q && (inl_inc > cfg_i.valid_needed)) begin
        trusted_d = 1'b1;
        res_o.dec = gfog_pkg::DecInitFix;
        res_o.x   = item_i.x;
        res_o.y   = item_i.y;
      end else if (trusted_q) begin
        res_o.x = item_i.x;
        res_o.y = item_i.y;
        if (item_i.fast) begin
          res_o.dec = gfog_pkg::DecPosHeading;
          res_o.mx  = item_i.mx;
          res_o.my  = item_i.my;
        end else begin
          res_o.dec = gfog_pkg::DecPosUpd;
        end
      end else begin
        res_o.dec = gfog_pkg::DecCollecting;
      end
    end else begin
      if (outl_inc > cfg_i.outlier_limit) begin
        trusted_d = 1'b0;
        inl_d     = '0;
        outl_d    = '0;
        kept_x_d  = item_i.x;
        kept_y_d  = item_i.y;
        kept_t_d  = item_i.arrival;
        res_o.dec = gfog_pkg::DecForcedReset;
      end else begin
        outl_d    = outl_inc;
        res_o.dec = gfog_pkg::DecOutlier;
      end
    end
    res_o.trusted = trusted_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trusted_q <= 1'b0;
      inl_q     <= '0;
      outl_q    <= '0;
      kept_x_q  <= '0;
      kept_y_q  <= '0;
      kept_t_q  <= '0;
    end else if (item_take_o) begin
      trusted_q <= trusted_d;
      inl_q     <= inl_d;
      outl_q    <= outl_d;
      kept_x_q  <= kept_x_d;
      kept_y_q  <= kept_y_d;
      kept_t_q  <= kept_t_d;
    end
  end

  a_drop_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_take_o && item_i.dropped |=> $stable(kept_t_q) && $stable(inl_q) && $stable(trusted_q))
    else $error("dropped fix changed tracking state");

  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o && (res_o.dec == gfog_pkg::DecForcedReset || res_o.dec == gfog_pkg::DecStale)
    |=> !trusted_q && inl_q == '0 && outl_q == '0)
    else $error("restart left counters or trust set");

  a_pos_needs_trust: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o && (res_o.dec == gfog_pkg::DecInitFix || res_o.dec == gfog_pkg::DecPosUpd ||
    res_o.dec == gfog_pkg::DecPosHeading) |-> res_o.trusted)
    else $error("position passed on while untrusted");

  a_inlier_keeps_fix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o && (res_o.dec == gfog_pkg::DecCollecting || res_o.dec == gfog_pkg::DecPosUpd)
    |=> kept_t_q == $past(item_i.arrival) && outl_q == '0)
    else $error("inlier not kept");

endmodule

FILE: rtl/gnss_fix_outlier_gate.sv
// ----------------------------------------------------------------------------
// gnss_fix_outlier_gate
// Qualifies GNSS fixes before they reach a position filter.
// ----------------------------------------------------------------------------
// Input side is a queue: a fix request is taken when push_i is high and full_o
// is low. Result side is a queue: the oldest decision is on the result ports
// while empty_o is low and leaves when pop_i is high. Every fix gives exactly
// one result, in order.
// The front classifies drop reasons and the motion speed test and writes into
// a two-entry queue; the back holds the tracking state, runs the stale and
// squared-distance checks and writes into a two-entry result queue.
// A taken fix is registered in the middle queue; the back then registers its
// decision into the result queue, from which it can be popped.
// Throughput: one fix per cycle unless the result queue is full, set by the
// back's state update (subtract, saturate, square, compare against kept fix).
// A stalled receiver fills the result queue, then the middle queue, and full_o
// rises; nothing is lost. Reset empties both queues, clears the tracking state
// and loads the register defaults. The user writes registers through cfg_we_i,
// cfg_idx_i and cfg_wdata_i only while no fix is in flight (not enforced).
// ----------------------------------------------------------------------------
module gnss_fix_outlier_gate #(
  parameter int unsigned MidDepth = gfog_pkg::MidQueueDepth,
  parameter int unsigned OutDepth = gfog_pkg::OutQueueDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [gfog_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [gfog_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          push_i,
  output logic                          full_o,
  input  logic [31:0]                   arrival_ms_i,
  input  logic                          rtk_fixed_i,
  input  logic [15:0]                   accuracy_mm_i,
  input  logic signed [31:0]            fix_x_mm_i,
  input  logic signed [31:0]            fix_y_mm_i,
  input  logic signed [15:0]            motion_x_mm_s_i,
  input  logic signed [15:0]            motion_y_mm_s_i,
  output logic                          empty_o,
  input  logic                          pop_i,
  output logic [3:0]                    decision_o,
  output logic                          fix_trusted_o,
  output logic signed [31:0]            out_x_mm_o,
  output logic signed [31:0]            out_y_mm_o,
  output logic signed [15:0]            out_motion_x_o,
  output logic signed [15:0]            out_motion_y_o
);

  localparam int unsigned ItemW = $bits(gfog_pkg::item_t);
  localparam int unsigned ResW  = $bits(gfog_pkg::result_t);

  gfog_pkg::cfg_t    cfg;
  gfog_pkg::item_t   front_item, back_item;
  gfog_pkg::result_t back_res, out_res;
  logic              mid_empty, back_take, res_push, res_full;

  gfog_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  gfog_front u_front (
    .cfg_i           (cfg),
    .arrival_ms_i    (arrival_ms_i),
    .rtk_fixed_i     (rtk_fixed_i),
    .accuracy_mm_i   (accuracy_mm_i),
    .fix_x_mm_i      (fix_x_mm_i),
    .fix_y_mm_i      (fix_y_mm_i),
    .motion_x_mm_s_i (motion_x_mm_s_i),
    .motion_y_mm_s_i (motion_y_mm_s_i),
    .item_o          (front_item)
  );

  gfog_fifo #(
    .Width (ItemW),
    .Depth (MidDepth)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (front_item),
    .full_o  (full_o),
    .pop_i   (back_take),
    .data_o  (back_item),
    .empty_o (mid_empty)
  );

  gfog_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (~mid_empty),
    .item_i       (back_item),
    .item_take_o  (back_take),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (back_res)
  );

  gfog_fifo #(
    .Width (ResW),
    .Depth (OutDepth)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (back_res),
    .full_o  (res_full),
    .pop_i   (pop_i),
    .data_o  (out_res),
    .empty_o (empty_o)
  );

  assign decision_o     = out_res.dec;
  assign fix_trusted_o  = out_res.trusted;
  assign out_x_mm_o     = out_res.x;
  assign out_y_mm_o     = out_res.y;
  assign out_motion_x_o = out_res.mx;
  assign out_motion_y_o = out_res.my;

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb - GNSS fix outlier gate testbench
// Drives fix requests through the push/full queue, pops decisions through the
// empty/pop queue and checks each against a cycle-free model of the gate.
// Directed fixes cover drops, staleness with wrap, boundary distances and
// every decision; random phases sweep the registers, extremes included.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import gfog_pkg::*;

typedef struct packed {
  logic [31:0]        arrival;
  logic               rtk;
  logic [15:0]        acc;
  logic signed [31:0] x;
  logic signed [31:0] y;
  logic signed [15:0] mx;
  logic signed [15:0] my;
} fix_t;

class gate_checker;
  logic        gate_en;
  logic [15:0] max_acc;
  logic [15:0] speed_lim;
  logic [15:0] stale_to;
  logic [15:0] jump_lim;
  logic [7:0]  valid_need;
  logic [3:0]  outl_lim;

  logic               trusted;
  logic [7:0]         inliers;
  logic [3:0]         outliers;
  logic signed [31:0] kx;
  logic signed [31:0] ky;
  logic [31:0]        kt;

  result_t expected_decisions[$];
  int      mismatches;
  int      decisions_checked;
  int      fixes_noted;
  int      dec_seen[10];

  function new();
    gate_en    = GateEnabledRst;
    max_acc    = MaxAccuracyRst;
    speed_lim  = 16'd10;
    stale_to   = StaleTimeoutRst;
    jump_lim   = 16'd5000;
    valid_need = ValidNeededRst;
    outl_lim   = OutlierLimitRst;
    restart_track(32'sd0, 32'sd0, 32'd0);
  endfunction

  function void restart_track(logic signed [31:0] x, logic signed [31:0] y, logic [31:0] t);
    trusted  = 1'b0;
    inliers  = '0;
    outliers = '0;
    kx       = x;
    ky       = y;
    kt       = t;
  endfunction

  function void set_reg(reg_idx_e idx, logic [15:0] v);
    case (idx)
      RegGateEnabled:  gate_en    = v[0];
      RegMaxAccuracy:  max_acc    = v;
      RegMinSpeed:     speed_lim  = v;
      RegStaleTimeout: stale_to   = v;
      RegJumpLimit:    jump_lim   = v;
      RegValidNeeded:  valid_need = v[7:0];
      RegOutlierLimit: outl_lim   = v[3:0];
      default: ;
    endcase
  endfunction

  function longint sat_delta(longint d);
    if (d > 65535) return 65535;
    if (d < -65535) return -65535;
    return d;
  endfunction

  function int pending();
    return expected_decisions.size();
  endfunction

  function void note_fix(fix_t f);
    result_t     r;
    longint      dx;
    longint      dy;
    longint      dsq;
    longint      lim;
    longint      sp;
    longint      ms;
    logic [31:0] elapsed;
    r = '0;
    fixes_noted++;
    if (!gate_en) begin
      r.dec = DecDisabled;
    end else if (!f.rtk) begin
      r.dec = DecNotRtk;
    end else if (f.acc > max_acc) begin
      r.dec = DecInaccurate;
    end else begin
      elapsed = f.arrival - kt;
      if (elapsed > {16'd0, stale_to}) begin
        restart_track(f.x, f.y, f.arrival);
        r.dec = DecStale;
      end else begin
        dx  = sat_delta(longint'(f.x) - longint'(kx));
        dy  = sat_delta(longint'(f.y) - longint'(ky));
        dsq = dx * dx + dy * dy;
        lim = longint'(jump_lim) * longint'(jump_lim);
        if (dsq < lim) begin
          kx       = f.x;
          ky       = f.y;
          kt       = f.arrival;
          outliers = '0;
          if (inliers != InlierMax) inliers++;
          if (!trusted && inliers > valid_need) begin
            trusted = 1'b1;
            r.dec   = DecInitFix;
            r.x     = f.x;
            r.y     = f.y;
          end else if (trusted) begin
            sp  = longint'(f.mx) * longint'(f.mx) + longint'(f.my) * longint'(f.my);
            ms  = longint'(speed_lim) * longint'(speed_lim);
            r.x = f.x;
            r.y = f.y;
            if (sp >= ms) begin
              r.dec = DecPosHeading;
              r.mx  = f.mx;
              r.my  = f.my;
            end else begin
              r.dec = DecPosUpd;
            end
          end else begin
            r.dec = DecCollecting;
          end
        end else begin
          if (outliers != OutlierMax) outliers++;
          if (outliers > outl_lim) begin
            restart_track(f.x, f.y, f.arrival);
            r.dec = DecForcedReset;
          end else begin
            r.dec = DecOutlier;
          end
        end
      end
    end
    r.trusted = trusted;
    expected_decisions.push_back(r);
  endfunction

  function void check_decision(result_t got);
    result_t want;
    if (expected_decisions.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: decision %0d popped with nothing outstanding", $realtime, got.dec);
      return;
    end
    want = expected_decisions.pop_front();
    decisions_checked++;
    if (want.dec <= DecForcedReset) dec_seen[want.dec]++;
    if (got.dec !== want.dec || got.trusted !== want.trusted || got.x !== want.x ||
        got.y !== want.y || got.mx !== want.mx || got.my !== want.my) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"%0t: decision %0d mismatch: expected dec=%0d trusted=%0b x=%0d y=%0d ",
                  "mx=%0d my=%0d, got dec=%0d trusted=%0b x=%0d y=%0d mx=%0d my=%0d"},
                 $realtime, decisions_checked, want.dec, want.trusted, want.x, want.y,
                 want.mx, want.my, got.dec, got.trusted, got.x, got.y, got.mx, got.my);
    end
  endfunction
endclass

module tb;

  localparam int StallLimit = 5000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = RegGateEnabled;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic               push_i = 1'b0;
  logic               full_o;
  logic [31:0]        arrival_ms_i = '0;
  logic               rtk_fixed_i = 1'b0;
  logic [15:0]        accuracy_mm_i = '0;
  logic signed [31:0] fix_x_mm_i = '0;
  logic signed [31:0] fix_y_mm_i = '0;
  logic signed [15:0] motion_x_mm_s_i = '0;
  logic signed [15:0] motion_y_mm_s_i = '0;
  logic               empty_o;
  logic               pop_i = 1'b0;
  logic [3:0]         decision_o;
  logic               fix_trusted_o;
  logic signed [31:0] out_x_mm_o;
  logic signed [31:0] out_y_mm_o;
  logic signed [15:0] out_motion_x_o;
  logic signed [15:0] out_motion_y_o;

  gate_checker sb = new();
  bit          no_idle = 1'b0;
  bit          hold_req = 1'b0;
  int          settings = 0;
  int          stall_cycles = 0;

  gnss_fix_outlier_gate dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .push_i,
    .full_o,
    .arrival_ms_i,
    .rtk_fixed_i,
    .accuracy_mm_i,
    .fix_x_mm_i,
    .fix_y_mm_i,
    .motion_x_mm_s_i,
    .motion_y_mm_s_i,
    .empty_o,
    .pop_i,
    .decision_o,
    .fix_trusted_o,
    .out_x_mm_o,
    .out_y_mm_o,
    .out_motion_x_o,
    .out_motion_y_o
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if ((push_i && !full_o) || (pop_i && !empty_o)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("watchdog: no request moved for %0d cycles", StallLimit);
      $display("** gnss_fix_outlier_gate: FAILED **");
      $finish;
    end
  end

  // result side: random pops, one long hold-off on request
  initial begin
    result_t got;
    int      hold_left;
    bit      want;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (pop_i && !empty_o) begin
        got.dec     = dec_e'(decision_o);
        got.trusted = fix_trusted_o;
        got.x       = out_x_mm_o;
        got.y       = out_y_mm_o;
        got.mx      = out_motion_x_o;
        got.my      = out_motion_y_o;
        sb.check_decision(got);
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 120;
      end
      if (hold_left > 0) begin
        hold_left--;
        want = 1'b0;
      end else begin
        want = no_idle || ($urandom_range(0, 99) >= 36);
      end
      pop_i <= want;
    end
  end

  function automatic fix_t mk_fix(logic [31:0] t, logic rtk, logic [15:0] acc,
                                  logic signed [31:0] x, logic signed [31:0] y,
                                  logic signed [15:0] mx, logic signed [15:0] my);
    fix_t f;
    f.arrival = t;
    f.rtk     = rtk;
    f.acc     = acc;
    f.x       = x;
    f.y       = y;
    f.mx      = mx;
    f.my      = my;
    return f;
  endfunction

  function automatic fix_t random_fix(bit stale_on);
    fix_t        f;
    int unsigned r;
    int unsigned j;
    int unsigned span;
    int unsigned spd;
    r    = $urandom_range(0, 99);
    j    = 32'(sb.jump_lim);
    span = j * 7 / 10;
    spd  = 32'(sb.speed_lim);
    f.rtk     = 1'b1;
    f.acc     = 16'($urandom_range(0, sb.max_acc));
    f.arrival = sb.kt + $urandom_range(0, sb.stale_to);
    f.x       = sb.kx;
    f.y       = sb.ky;
    if ($urandom_range(0, 1)) begin
      f.mx = 16'($urandom);
      f.my = 16'($urandom);
    end else begin
      f.mx = 16'($urandom_range(0, spd));
      f.my = 16'($urandom_range(0, spd / 2));
      if ($urandom_range(0, 1)) f.mx = -f.mx;
      if ($urandom_range(0, 1)) f.my = -f.my;
    end
    if (r < 5) begin
      f.rtk     = 1'b0;
      f.arrival = $urandom;
      f.acc     = 16'($urandom);
    end else if (r < 10) begin
      f.acc = (sb.max_acc == 16'hFFFF) ? 16'($urandom)
                                       : 16'($urandom_range(sb.max_acc + 1, 65535));
    end else if (r < 14 && stale_on) begin
      if ($urandom_range(0, 3) == 0) f.arrival = $urandom;
      else f.arrival = sb.kt + sb.stale_to + 1 + $urandom_range(0, 1000);
    end else if (r < 24) begin
      f.x = $urandom;
      f.y = $urandom;
    end else if (r < 30) begin
      // just on or just inside the jump limit along one axis
      if ($urandom_range(0, 1)) begin
        f.x = $urandom_range(0, 1) ? sb.kx + (j - $urandom_range(0, 1))
                                   : sb.kx - (j - $urandom_range(0, 1));
      end else begin
        f.y = $urandom_range(0, 1) ? sb.ky + (j - $urandom_range(0, 1))
                                   : sb.ky - (j - $urandom_range(0, 1));
      end
    end else begin
      f.x = sb.kx + $urandom_range(0, 2 * span) - span;
      f.y = sb.ky + $urandom_range(0, 2 * span) - span;
    end
    return f;
  endfunction

  task automatic send_fix(fix_t f);
    while (!no_idle && $urandom_range(0, 99) < 36) begin
      push_i <= 1'b0;
      @(posedge clk_i);
    end
    push_i          <= 1'b1;
    arrival_ms_i    <= f.arrival;
    rtk_fixed_i     <= f.rtk;
    accuracy_mm_i   <= f.acc;
    fix_x_mm_i      <= f.x;
    fix_y_mm_i      <= f.y;
    motion_x_mm_s_i <= f.mx;
    motion_y_mm_s_i <= f.my;
    do @(posedge clk_i); while (full_o);
    sb.note_fix(f);
  endtask

  task automatic run_fixes(int n, bit stale_on);
    for (int i = 0; i < n; i++) send_fix(random_fix(stale_on));
  endtask

  task automatic settle();
    push_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [15:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
  endtask

  task automatic apply_cfg(logic gate, logic [15:0] acc, logic [15:0] speed,
                           logic [15:0] stale, logic [15:0] jump, logic [7:0] valid,
                           logic [3:0] outl);
    write_reg(RegGateEnabled, {15'd0, gate});
    write_reg(RegMaxAccuracy, acc);
    write_reg(RegMinSpeed, speed);
    write_reg(RegStaleTimeout, stale);
    write_reg(RegJumpLimit, jump);
    write_reg(RegValidNeeded, {8'd0, valid});
    write_reg(RegOutlierLimit, {12'd0, outl});
    cfg_we_i <= 1'b0;
    settings++;
  endtask

  task automatic rand_cfg(logic gate);
    logic [15:0] acc;
    acc = $urandom_range(0, 1) ? 16'($urandom_range(0, 500)) : 16'($urandom_range(0, 65535));
    apply_cfg(gate, acc, 16'($urandom_range(0, 3000)), 16'($urandom_range(0, 65535)),
              16'($urandom_range(1, 65535)), 8'($urandom_range(0, 12)),
              4'($urandom_range(0, 15)));
  endtask

  initial begin
    string tally;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // defaults: drops, first fix against the cleared track, boundaries, wrap
    send_fix(mk_fix(32'hFFFF_FFFF, 1'b0, 16'hFFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
                    16'sh7FFF, 16'sh8000));
    send_fix(mk_fix(32'd0, 1'b1, 16'd101, 32'sd0, 32'sd0, 16'sd0, 16'sd0));
    send_fix(mk_fix(32'd0, 1'b1, 16'd100, 32'sd0, 32'sd0, 16'sd3, 16'sd4));
    send_fix(mk_fix(32'd5000, 1'b1, 16'd0, 32'sd4999, 32'sd0, 16'sd0, 16'sd0));
    send_fix(mk_fix(32'd5000, 1'b1, 16'd0, 32'sd9999, 32'sd0, 16'sd0, 16'sd0));
    send_fix(mk_fix(32'd5000, 1'b1, 16'd0, 32'sh7FFF_FFFF, 32'sh8000_0000, 16'sd0, 16'sd0));
    send_fix(mk_fix(32'd10001, 1'b1, 16'd0, -32'sd100, -32'sd100, 16'sd0, 16'sd0));
    send_fix(mk_fix(32'd0, 1'b1, 16'd0, -32'sd100, -32'sd100, 16'sd0, 16'sd0));
    settle();

    apply_cfg(1'b1, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 8'd0, 4'd0);
    send_fix(mk_fix(32'd100, 1'b1, 16'hFFFF, 32'sd1000, -32'sd2000, 16'sd5, 16'sd5));
    send_fix(mk_fix(32'd200, 1'b1, 16'd7, 32'sd1500, -32'sd2500, 16'sh8000, 16'sh8000));
    send_fix(mk_fix(32'd300, 1'b1, 16'd7, 32'sh8000_0000, 32'sh7FFF_FFFF, 16'sd1, 16'sd1));
    settle();

    apply_cfg(1'b1, 16'd100, 16'hFFFF, 16'd5000, 16'd5000, 8'd0, 4'd15);
    send_fix(mk_fix(32'd310, 1'b1, 16'd100, 32'sh8000_000A, 32'sh7FFF_FFFF, 16'sd0, 16'sd0));
    send_fix(mk_fix(32'd320, 1'b1, 16'd50, 32'sh8000_0010, 32'sh7FFF_FFF0,
                    16'sh7FFF, 16'sh7FFF));
    send_fix(mk_fix(32'd330, 1'b1, 16'd50, 32'sd0, 32'sd0, 16'sd0, 16'sd0));
    settle();

    apply_cfg(1'b0, 16'd100, 16'd10, 16'd5000, 16'd5000, 8'd10, 4'd10);
    send_fix(mk_fix(32'd340, 1'b0, 16'hFFFF, 32'sd0, 32'sd0, 16'sd0, 16'sd0));
    send_fix(mk_fix(32'd350, 1'b1, 16'd0, 32'sd0, 32'sd0, 16'sd0, 16'sd0));
    settle();

    // register extremes, then a long quiet run that saturates the inlier count
    apply_cfg(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 4'hF);
    run_fixes(150, 1'b1);
    settle();
    apply_cfg(1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0, 4'd0);
    run_fixes(100, 1'b1);
    settle();
    apply_cfg(1'b1, 16'hFFFF, 16'($urandom_range(0, 3000)), 16'hFFFF, 16'hFFFF, 8'd254, 4'hF);
    run_fixes(400, 1'b0);
    settle();
    rand_cfg(1'b0);
    run_fixes(50, 1'b1);
    settle();

    for (int k = 0; k < 8; k++) begin
      rand_cfg(1'b1);
      no_idle = (k == 2);
      if (k == 4) hold_req = 1'b1;
      run_fixes(78, 1'b1);
      if (k == 4) settle();
      run_fixes(78, 1'b1);
      settle();
      no_idle = 1'b0;
    end

    repeat (8) @(posedge clk_i);
    tally = "";
    for (int d = 0; d < 10; d++) tally = {tally, $sformatf(" %0d:%0d", d, sb.dec_seen[d])};
    $display("%0d fixes over %0d register settings, %0d decisions checked, %0d mismatches",
             sb.fixes_noted, settings, sb.decisions_checked, sb.mismatches);
    $display("decision code:count%s", tally);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("** gnss_fix_outlier_gate: PASSED **");
    end else begin
      $display("** gnss_fix_outlier_gate: FAILED **");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/gfog_pkg.sv
rtl/gfog_fifo.sv
rtl/gfog_cfg.sv
rtl/gfog_front.sv
rtl/gfog_back.sv
rtl/gnss_fix_outlier_gate.sv
test/tb.sv
